// ----- sv/battery_voltage_monitor_defines.svh -----
// Assertion macros shared by the battery voltage monitor RTL.
`ifndef BATTERY_VOLTAGE_MONITOR_DEFINES_SVH
`define BATTERY_VOLTAGE_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while arst_n is low.
`define BVM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and ignored while arst_n is low.
`define BVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/bvm_pkg.sv -----
// Types, constants and helper functions of the battery voltage monitor.
package bvm_pkg;

	localparam int DVD_W    = 33;
	localparam int DVS_W    = 20;
	localparam int QUOT_W   = 16;
	localparam int MV_W     = 16;
	localparam int PCT_W    = 7;
	localparam int CURVE_PTS = 12;

	typedef enum logic [1:0] {
		STAT_ACCEPTED   = 2'd0,
		STAT_NO_SAMPLES = 2'd1,
		STAT_IMPLAUSIBLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_CRITICAL_MV  = 3'd0,
		REG_LOW_MV       = 3'd1,
		REG_PLAUS_MIN_MV = 3'd2,
		REG_PLAUS_MAX_MV = 3'd3,
		REG_STREAK_NEED  = 3'd4,
		REG_DIV_TOTAL    = 3'd5,
		REG_DIV_TAP      = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quotient;
	} div_rsp_t;

	localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
		16'd4200, 16'd4100, 16'd4000, 16'd3950, 16'd3870, 16'd3820,
		16'd3790, 16'd3750, 16'd3700, 16'd3600, 16'd3400, 16'd3000
	};

	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_PTS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
	};

	// First curve point at or below mv, searched from the second point on.
	// Only meaningful when mv lies below the top point and at or above the last.
	function automatic logic [3:0] curve_seg(input logic [MV_W-1:0] mv);
		logic [3:0] seg;
		seg = 4'd1;
		for (int k = CURVE_PTS - 1; k >= 1; k--) begin
			if (mv >= CURVE_MV[k]) begin
				seg = 4'(k);
			end
		end
		return seg;
	endfunction

endpackage

// ----- sv/bvm_div.sv -----
// Shared restoring divider with a saturated 16-bit quotient, one bit per cycle.
`include "battery_voltage_monitor_defines.svh"

module bvm_div
	import bvm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              sat_q;
	logic              done_q;
	logic [3:0]        cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  divisor_q;
	logic [QUOT_W-1:0] low_q;

	logic              sat_w;
	logic [DVS_W:0]    trial_w;
	logic              ge_w;
	logic [DVS_W-1:0]  rem_nxt_w;

	// A quotient that would not fit in 16 bits, or a zero divisor, saturates.
	assign sat_w = (req.divisor == '0) ||
		({3'b000, req.dividend[DVD_W-1:QUOT_W]} >= req.divisor);

	assign trial_w   = {rem_q, low_q[QUOT_W-1]};
	assign ge_w      = trial_w >= {1'b0, divisor_q};
	assign rem_nxt_w = ge_w ? DVS_W'(trial_w - {1'b0, divisor_q}) : trial_w[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sat_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				sat_q  <= sat_w;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (sat_q || cnt_q == 4'hF) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= {3'b000, req.dividend[DVD_W-1:QUOT_W]};
			low_q     <= req.dividend[QUOT_W-1:0];
		end else if (busy_q && !sat_q) begin
			rem_q <= rem_nxt_w;
			low_q <= {low_q[QUOT_W-2:0], ge_w};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = sat_q ? {QUOT_W{1'b1}} : low_q;

	`BVM_ASSERT_NOW(a_div_start_idle, req.start, !busy_q, "divider started while busy")
	`BVM_ASSERT_NOW(a_div_done_idle, done_q, !busy_q, "divider done while still busy")
	`BVM_ASSERT_NEXT(a_div_sat_fast, busy_q && sat_q && !req.start, done_q,
		"saturated division did not finish at once")

endmodule

// ----- sv/battery_voltage_monitor.sv -----
// Top level of the battery voltage monitor: sample averaging, plausibility and fuel gauge.
//
//   channel  direction  handshake                fields
//   cfg      in         cfg_we                   cfg_index, cfg_data
//   in       in         in_valid / in_stall      pin_mv, sample_ok
//   out      out        out_valid / out_stall    status .. lockout
//
// A good sample keeps in_stall high after acceptance while the shared divider scales it up,
// a pass that ends early when its quotient saturates; a failed sample only while it is counted.
// Closing a read adds an average and an interpolation division, only the average when the
// curve ends or the window decide at once, none with no good sample, plus any out_stall wait.
// Reset clears the sequencer, the sums, the streak, the lockout and the held reading.
// A stalled result waits in the output register; only the next read's closing item waits on it.
`include "battery_voltage_monitor_defines.svh"

module battery_voltage_monitor
	import bvm_pkg::*;
#(
	parameter int ATTEMPTS_PER_READ = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [12:0] pin_mv,
	input  logic        sample_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] measured_mv,
	output logic [15:0] cell_mv,
	output logic        reading_valid,
	output logic [6:0]  percent,
	output logic        low_warning,
	output logic        window_fault,
	output logic        lockout
);

	// The sequencer walks one item through the shared divider, one phase per state.
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MUL     = 7'b0000010,
		ST_DIVGO   = 7'b0000100,
		ST_DIVWAIT = 7'b0001000,
		ST_ACC     = 7'b0010000,
		ST_CHECK   = 7'b0100000,
		ST_EMIT    = 7'b1000000
	} state_t;

	// Which computation the divider is currently serving.
	typedef enum logic [1:0] {
		OP_SCALE = 2'd0,
		OP_AVG   = 2'd1,
		OP_GAUGE = 2'd2
	} op_t;

	// Configuration registers.
	logic [MV_W-1:0]  critical_mv_q;
	logic [MV_W-1:0]  low_mv_q;
	logic [MV_W-1:0]  plaus_min_q;
	logic [MV_W-1:0]  plaus_max_q;
	logic [3:0]       streak_need_q;
	logic [DVS_W-1:0] div_total_q;
	logic [DVS_W-1:0] div_tap_q;

	// Sequencer and running read state.
	state_t           state_q;
	op_t              op_q;
	logic [1:0]       attempt_q;
	logic [2:0]       good_q;
	logic [17:0]      sum_q;
	logic [3:0]       streak_q;
	logic             lockout_q;
	logic             fault_q;
	logic [MV_W-1:0]  held_mv_q;
	logic [PCT_W-1:0] held_pct_q;
	logic             have_q;
	status_t          code_q;

	// Item payload and divider operands.
	logic [12:0]      pin_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [MV_W-1:0]  avg_q;
	logic [PCT_W-1:0] base_pct_q;

	// Output register.
	logic             out_valid_q;
	status_t          out_status_q;
	logic [MV_W-1:0]  out_meas_q;
	logic [MV_W-1:0]  out_cell_q;
	logic             out_have_q;
	logic [PCT_W-1:0] out_pct_q;
	logic             out_low_q;
	logic             out_fault_q;
	logic             out_lock_q;

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic [DVD_W-1:0] scale_prod_w;
	logic             last_attempt_w;
	logic             plausible_w;
	logic [3:0]       streak_nxt_w;
	logic [3:0]       seg_w;
	logic [MV_W-1:0]  span_w;
	logic [3:0]       rise_w;
	logic [8:0]       diff_w;
	logic [12:0]      gprod_w;
	logic             out_free_w;

	bvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Pin millivolts times total ohms; at most 33 bits, divided by the tap ohms next.
	assign scale_prod_w = pin_q * div_total_q;

	assign last_attempt_w = ({1'b0, attempt_q} + 3'd1) >= 3'(ATTEMPTS_PER_READ);

	// An inverted window makes every average implausible, which these compares give as is.
	assign plausible_w = (avg_q >= plaus_min_q) && (avg_q <= plaus_max_q);

	// The streak counts critical readings in a row and holds at its top.
	assign streak_nxt_w = (avg_q <= critical_mv_q) ?
		((streak_q == 4'hF) ? streak_q : streak_q + 4'd1) : 4'd0;

	// Interpolation segment between curve points seg_w - 1 and seg_w. The span is at
	// most 400 mV and the rise at most 10 percent, so the partial product fits 13 bits.
	assign seg_w   = curve_seg(avg_q);
	assign span_w  = CURVE_MV[seg_w - 4'd1] - CURVE_MV[seg_w];
	assign rise_w  = 4'(CURVE_PCT[seg_w - 4'd1] - CURVE_PCT[seg_w]);
	assign diff_w  = 9'(avg_q - CURVE_MV[seg_w]);
	assign gprod_w = diff_w * rise_w;

	assign div_req.start    = (state_q == ST_DIVGO);
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dvs_q;

	// The output register can take a new result when empty or being drained this cycle.
	assign out_free_w = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);

	// Configuration writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			critical_mv_q <= 16'd3100;
			low_mv_q      <= 16'd3400;
			plaus_min_q   <= 16'd2500;
			plaus_max_q   <= 16'd4350;
			streak_need_q <= 4'd3;
			div_total_q   <= 20'd1;
			div_tap_q     <= 20'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CRITICAL_MV:  critical_mv_q <= cfg_data[MV_W-1:0];
				REG_LOW_MV:       low_mv_q      <= cfg_data[MV_W-1:0];
				REG_PLAUS_MIN_MV: plaus_min_q   <= cfg_data[MV_W-1:0];
				REG_PLAUS_MAX_MV: plaus_max_q   <= cfg_data[MV_W-1:0];
				REG_STREAK_NEED:  streak_need_q <= cfg_data[3:0];
				REG_DIV_TOTAL:    div_total_q   <= cfg_data;
				REG_DIV_TAP:      div_tap_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and the state that persists across reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_SCALE;
			attempt_q  <= '0;
			good_q     <= '0;
			sum_q      <= '0;
			streak_q   <= '0;
			lockout_q  <= 1'b0;
			fault_q    <= 1'b0;
			held_mv_q  <= '0;
			held_pct_q <= '0;
			have_q     <= 1'b0;
			code_q     <= STAT_ACCEPTED;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// A failed attempt still counts but adds nothing to the sum.
					if (in_valid) begin
						state_q <= sample_ok ? ST_MUL : ST_ACC;
					end
				end
				ST_MUL: begin
					op_q    <= OP_SCALE;
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_rsp.done) begin
						unique case (op_q)
							OP_SCALE: begin
								sum_q   <= sum_q + 18'(div_rsp.quotient);
								good_q  <= good_q + 3'd1;
								state_q <= ST_ACC;
							end
							OP_AVG: begin
								state_q <= ST_CHECK;
							end
							OP_GAUGE: begin
								held_pct_q <= base_pct_q + PCT_W'(div_rsp.quotient);
								state_q    <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ACC: begin
					priority if (!last_attempt_w) begin
						attempt_q <= attempt_q + 2'd1;
						state_q   <= ST_IDLE;
					end else if (good_q == 3'd0) begin
						// No good sample in this read: report it and touch nothing else.
						code_q  <= STAT_NO_SAMPLES;
						state_q <= ST_EMIT;
					end else begin
						op_q    <= OP_AVG;
						state_q <= ST_DIVGO;
					end
				end
				ST_CHECK: begin
					if (!plausible_w) begin
						// A broken sense circuit flags a fault and breaks the streak.
						code_q   <= STAT_IMPLAUSIBLE;
						fault_q  <= 1'b1;
						streak_q <= '0;
						state_q  <= ST_EMIT;
					end else begin
						code_q    <= STAT_ACCEPTED;
						fault_q   <= 1'b0;
						held_mv_q <= avg_q;
						have_q    <= 1'b1;
						streak_q  <= streak_nxt_w;
						// Lockout latches here and is only cleared by reset.
						if (streak_nxt_w >= streak_need_q) begin
							lockout_q <= 1'b1;
						end
						// At or above the top point reads full, below the last point empty;
						// in between the divider interpolates within the segment.
						priority if (avg_q >= CURVE_MV[0]) begin
							held_pct_q <= CURVE_PCT[0];
							state_q    <= ST_EMIT;
						end else if (avg_q < CURVE_MV[CURVE_PTS-1]) begin
							held_pct_q <= CURVE_PCT[CURVE_PTS-1];
							state_q    <= ST_EMIT;
						end else begin
							op_q    <= OP_GAUGE;
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_EMIT: begin
					if (out_free_w) begin
						attempt_q <= '0;
						good_q    <= '0;
						sum_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers and divider operands.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pin_q <= pin_mv;
		end
		if (state_q == ST_MUL) begin
			dvd_q <= scale_prod_w;
			dvs_q <= div_tap_q;
		end
		if (state_q == ST_ACC) begin
			dvd_q <= DVD_W'(sum_q);
			dvs_q <= DVS_W'(good_q);
		end
		if (state_q == ST_DIVWAIT && div_rsp.done && op_q == OP_AVG) begin
			avg_q <= div_rsp.quotient;
		end
		if (state_q == ST_CHECK) begin
			dvd_q      <= DVD_W'(gprod_w);
			dvs_q      <= DVS_W'(span_w);
			base_pct_q <= CURVE_PCT[seg_w];
		end
	end

	// Output register: one result per read, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free_w) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free_w) begin
			out_status_q <= code_q;
			out_meas_q   <= (code_q == STAT_NO_SAMPLES) ? '0 : avg_q;
			out_cell_q   <= held_mv_q;
			out_have_q   <= have_q;
			out_pct_q    <= held_pct_q;
			out_low_q    <= have_q && (held_mv_q <= low_mv_q);
			out_fault_q  <= fault_q;
			out_lock_q   <= lockout_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign measured_mv   = out_meas_q;
	assign cell_mv       = out_cell_q;
	assign reading_valid = out_have_q;
	assign percent       = out_pct_q;
	assign low_warning   = out_low_q;
	assign window_fault  = out_fault_q;
	assign lockout       = out_lock_q;

	`BVM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block still ready after taking an item")
	`BVM_ASSERT_NEXT(a_lockout_sticks, lockout_q, lockout_q, "lockout released without reset")
	`BVM_ASSERT_NOW(a_good_bounded, 1'b1, good_q <= 3'(ATTEMPTS_PER_READ),
		"more good samples than attempts in a read")
	`BVM_ASSERT_NOW(a_pct_bounded, 1'b1, held_pct_q <= CURVE_PCT[0],
		"held percent above full charge")

endmodule
